### hw/rtl/prlf_pkg.sv
// Shared types and constants for the page replacement unit.
`default_nettype none
package prlf_pkg;

  localparam int unsigned PAGE_W       = 16;
  localparam int unsigned FRAMES_W     = 5;
  localparam int unsigned CFG_DATA_W   = 5;
  localparam int unsigned CFG_INDEX_W  = 1;
  localparam int unsigned FRAMES_RESET = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POLICY = 1'b1;

  // Replacement policy codes.
  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  // Per-cell update control.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### hw/rtl/page_replacement_lru_fifo_unit.sv
// Top level of the LRU / FIFO page replacement unit: a chain of frame cells and its control.
// Top-level note: a reference is accepted while start is high and busy is low; its result, marked
// by done, is registered in the next cycle. Accepts one reference per cycle while busy is low; every
// frame cell compares in parallel and the whole chain updates together. After a write that lowers the
// frame count below the occupancy, busy stays high while the chain shifts out one page at a time.
// Synchronous reset empties all frames, clears the fault count and restores 4 frames, LRU.
`default_nettype none
module page_replacement_lru_fifo_unit #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [15:0] page_number,
  input  wire         wr_en,
  input  wire  [0:0]  wr_index,
  input  wire  [4:0]  wr_data,
  output logic        done,
  output logic        hit,
  output logic        evicted_valid,
  output logic [15:0] evicted_page,
  output logic [15:0] fault_count,
  output logic [4:0]  resident_count
);

  localparam int unsigned PW = (PAGE_BITS < prlf_pkg::PAGE_W) ? PAGE_BITS : prlf_pkg::PAGE_W;
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned LIMIT_RST =
    (prlf_pkg::FRAMES_RESET > MAX_FRAMES) ? MAX_FRAMES : prlf_pkg::FRAMES_RESET;

  logic [CW-1:0] occupancy;
  logic [CW-1:0] limit;
  logic          policy;
  logic [15:0]   faults;

  logic [PW-1:0]   ref_page;
  logic [PW-1:0]   cell_page  [MAX_FRAMES];
  logic            cell_valid [MAX_FRAMES];
  logic [PW-1:0]   nb_page    [MAX_FRAMES];
  logic            nb_valid   [MAX_FRAMES];
  logic [MAX_FRAMES:0] match_chain;
  prlf_pkg::cell_ctrl_t ctrl [MAX_FRAMES];

  logic          accept;
  logic          ref_hit;
  logic          evict;
  logic          lru_hit;
  logic          shift_all;
  logic          load_en;
  logic [CW-1:0] ins_pos;
  logic [CW-1:0] limit_next;

  assign ref_page  = page_number[PW-1:0];
  assign busy      = occupancy > limit;
  assign accept    = start & ~busy;
  assign ref_hit   = match_chain[MAX_FRAMES];
  assign evict     = ~ref_hit & (occupancy >= limit);
  assign lru_hit   = ref_hit & (policy == prlf_pkg::POLICY_LRU);
  // A trim pass and an eviction both drop the entry at position zero.
  assign shift_all = (accept & evict) | busy;
  assign load_en   = accept & (~ref_hit | lru_hit);
  assign ins_pos   = (evict | ref_hit) ? occupancy - CW'(1) : occupancy;
  assign match_chain[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < MAX_FRAMES; g++) begin : g_cell
      if (g == MAX_FRAMES - 1) begin : g_top
        assign nb_page[g]  = '0;
        assign nb_valid[g] = 1'b0;
      end else begin : g_mid
        assign nb_page[g]  = cell_page[g+1];
        assign nb_valid[g] = cell_valid[g+1];
      end

      assign ctrl[g].shift = shift_all | (accept & lru_hit & match_chain[g+1]);
      assign ctrl[g].load  = load_en & (ins_pos == CW'(g));

      prlf_cell #(.PW(PW)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl[g]),
        .ref_page  (ref_page),
        .nb_page   (nb_page[g]),
        .nb_valid  (nb_valid[g]),
        .match_in  (match_chain[g]),
        .match_out (match_chain[g+1]),
        .page      (cell_page[g]),
        .valid     (cell_valid[g])
      );
    end
  endgenerate

  // A frame count of zero acts as one; counts above the chain length act as the full chain.
  always_comb begin
    if (wr_data == '0) begin
      limit_next = CW'(1);
    end else if (32'(wr_data) > 32'(MAX_FRAMES)) begin
      limit_next = CW'(MAX_FRAMES);
    end else begin
      limit_next = CW'(wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit  <= CW'(LIMIT_RST);
      policy <= prlf_pkg::POLICY_LRU;
    end else if (wr_en) begin
      if (wr_index == prlf_pkg::CFG_FRAMES) begin
        limit <= limit_next;
      end else begin
        policy <= wr_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      faults    <= '0;
    end else if (busy) begin
      occupancy <= occupancy - CW'(1);
    end else if (accept & ~ref_hit) begin
      if (!evict) begin
        occupancy <= occupancy + CW'(1);
      end
      if (faults != 16'hFFFF) begin
        faults <= faults + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done           <= 1'b0;
      hit            <= 1'b0;
      evicted_valid  <= 1'b0;
      evicted_page   <= '0;
      fault_count    <= '0;
      resident_count <= '0;
    end else begin
      done <= accept;
      if (accept) begin
        hit           <= ref_hit;
        evicted_valid <= evict;
        evicted_page  <= evict ? 16'(cell_page[0]) : 16'd0;
        if (!ref_hit && faults != 16'hFFFF) begin
          fault_count <= faults + 16'd1;
        end else begin
          fault_count <= faults;
        end
        if (!ref_hit && !evict) begin
          resident_count <= 5'(occupancy + CW'(1));
        end else begin
          resident_count <= 5'(occupancy);
        end
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/prlf_cell.sv
// One frame cell: holds a resident page, compares it and shifts toward position zero.
`default_nettype none
module prlf_cell #(
  parameter int unsigned PW = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  prlf_pkg::cell_ctrl_t ctrl,
  input  wire  [PW-1:0]       ref_page,
  input  wire  [PW-1:0]       nb_page,
  input  wire                 nb_valid,
  input  wire                 match_in,
  output logic                match_out,
  output logic [PW-1:0]       page,
  output logic                valid
);

  // The match carry runs up the chain, so match_out marks this cell and all above a hit.
  assign match_out = match_in | (valid & (page == ref_page));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.load) begin
      valid <= 1'b1;
    end else if (ctrl.shift) begin
      valid <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      page <= ref_page;
    end else if (ctrl.shift) begin
      page <= nb_page;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/prlf_checker.sv
// Port-level checks for the page replacement unit, bound to the top level.
`default_nettype none
module prlf_checker (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        done,
  input wire        hit,
  input wire        evicted_valid,
  input wire [15:0] evicted_page,
  input wire [15:0] fault_count,
  input wire [4:0]  resident_count
);

  // Every accepted reference gives exactly one result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted reference gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without an accepted reference");

  // A hit never evicts, and a hit reports an evicted page number of zero.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (!evicted_valid && evicted_page == 16'd0))
    else $error("hit reported an eviction");

  // A fault always leaves the fault count above zero and at least one page resident.
  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (fault_count != 16'd0 && resident_count != 5'd0))
    else $error("fault not reflected in counters");

endmodule

bind page_replacement_lru_fifo_unit prlf_checker u_prlf_checker (.*);
`default_nettype wire
